>>> sv/tptl_pkg.sv
// shared types and constants for the paged translation core
package tptl_pkg;

  localparam int ADDR_W       = 16;
  localparam int OFFSET_W     = 8;
  localparam int FIELD_PAGE_W = 8;
  localparam int PHYS_W       = 15;
  localparam int WIDE_W       = 32;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  typedef struct packed {
    logic touch;
    logic push;
  } lru_ctl_t;

endpackage

>>> sv/tptl_lru_cell.sv
// one position of the lru stack: holds a resident page and its frame
module tptl_lru_cell #(
  parameter int PW = 8,
  parameter int FW = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  tptl_pkg::lru_ctl_t ctl,
  input  logic [PW-1:0]      cmp_page,
  input  logic               up_valid,
  input  logic [PW-1:0]      up_page,
  input  logic [FW-1:0]      up_frame,
  input  logic               seen_in,
  output logic               seen_out,
  output logic               valid,
  output logic [PW-1:0]      page,
  output logic [FW-1:0]      frame
);

  logic match;
  logic shift;

  // on a touch, cells from the head down to the matching one move by one place; on a push every cell moves
  assign match    = valid && (page == cmp_page);
  assign seen_out = seen_in | match;
  assign shift    = ctl.push | (ctl.touch & !seen_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page  <= up_page;
      frame <= up_frame;
    end
  end

endmodule

>>> sv/tptl_lru_chain.sv
// row of lru cells, most recent at the head, least recent at the tail
module tptl_lru_chain #(
  parameter int CELLS = 128,
  parameter int PW    = 8,
  parameter int FW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  tptl_pkg::lru_ctl_t ctl,
  input  logic [PW-1:0]      new_page,
  input  logic [FW-1:0]      new_frame,
  output logic               victim_valid,
  output logic [PW-1:0]      victim_page,
  output logic [FW-1:0]      victim_frame
);

  logic          c_valid [CELLS];
  logic [PW-1:0] c_page  [CELLS];
  logic [FW-1:0] c_frame [CELLS];
  logic          c_seen  [CELLS];

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      tptl_lru_cell #(.PW(PW), .FW(FW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .cmp_page (new_page),
        .up_valid (1'b1),
        .up_page  (new_page),
        .up_frame (new_frame),
        .seen_in  (1'b0),
        .seen_out (c_seen[i]),
        .valid    (c_valid[i]),
        .page     (c_page[i]),
        .frame    (c_frame[i])
      );
    end else begin : g_body
      tptl_lru_cell #(.PW(PW), .FW(FW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .cmp_page (new_page),
        .up_valid (c_valid[i-1]),
        .up_page  (c_page[i-1]),
        .up_frame (c_frame[i-1]),
        .seen_in  (c_seen[i-1]),
        .seen_out (c_seen[i]),
        .valid    (c_valid[i]),
        .page     (c_page[i]),
        .frame    (c_frame[i])
      );
    end
  end

  assign victim_valid = c_valid[CELLS-1];
  assign victim_page  = c_page[CELLS-1];
  assign victim_frame = c_frame[CELLS-1];

endmodule

>>> sv/tlb_paged_translation_lru_core.sv
// Demand-paging address translator with a FIFO-filled TLB and an LRU stack of frames.
// A request is handled in S_IDLE, which registers the address and reads the page-table
// memory as it is accepted, then in S_LOOK, which compares the TLB, decides hit, miss or
// fault, and moves the LRU stack (a row of FRAME_COUNT cells) by one step; a new request
// is not taken until the last one has left S_LOOK. The input stalls while a request is in
// S_LOOK, and S_LOOK waits while a finished result in the output register is still stalled.
// Residency bits reset at once; no clearing pass runs after reset.
module tlb_paged_translation_lru_core #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] logical_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] physical_address,
  output logic        tlb_hit,
  output logic        page_fault,
  output logic        evicted_valid,
  output logic [7:0]  evicted_page
);

  localparam int PW  = $clog2(PAGE_COUNT);
  localparam int FW  = $clog2(FRAME_COUNT);
  localparam int TW  = $clog2(TLB_ENTRIES);
  localparam int UW  = $clog2(FRAME_COUNT + 1);
  localparam int RW  = 14;
  localparam int OW  = tptl_pkg::OFFSET_W;
  localparam int EPW = tptl_pkg::FIELD_PAGE_W;
  localparam int XW  = tptl_pkg::WIDE_W;
  localparam int QW  = tptl_pkg::PHYS_W;

  tptl_pkg::state_t state, state_next;
  tptl_pkg::lru_ctl_t ctl;

  logic          accept;
  logic          go;
  logic [RW-1:0] rem;
  logic [PW-1:0] in_page;

  logic [PW-1:0] page;
  logic [OW-1:0] offset;
  logic [FW-1:0] mem_q;
  logic [FW-1:0] page_frame [PAGE_COUNT];
  logic          resident [PAGE_COUNT];

  logic [PW-1:0] tlb_page  [TLB_ENTRIES];
  logic [FW-1:0] tlb_frame [TLB_ENTRIES];
  logic          tlb_valid [TLB_ENTRIES];
  logic [TW-1:0] fill_ptr;
  logic [UW-1:0] frames_used;

  logic [TLB_ENTRIES-1:0] tlb_match;
  logic          hit;
  logic [FW-1:0] hit_frame;
  logic          full;
  logic          do_touch;
  logic          do_push;
  logic          do_fill;
  logic          fault;
  logic          evict;
  logic [FW-1:0] frame;
  logic [XW-1:0] phys_wide;

  logic          victim_valid;
  logic [PW-1:0] victim_page;
  logic [FW-1:0] victim_frame;

  assign accept = in_valid && !in_stall;

  // page number wraps modulo the table size
  always_comb begin
    rem = RW'(logical_address[15:8]);
    for (int k = 3; k >= 0; k--) begin
      if (rem >= RW'(PAGE_COUNT << k)) begin
        rem = rem - RW'(PAGE_COUNT << k);
      end
    end
    in_page = rem[PW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tptl_pkg::S_IDLE: if (accept) state_next = tptl_pkg::S_LOOK;
      tptl_pkg::S_LOOK: if (go) state_next = tptl_pkg::S_IDLE;
      default: state_next = tptl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    go       = 1'b0;
    unique case (state)
      tptl_pkg::S_IDLE: in_stall = 1'b0;
      tptl_pkg::S_LOOK: go = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tptl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page   <= in_page;
      offset <= logical_address[7:0];
      mem_q  <= page_frame[in_page];
    end
  end

  always_ff @(posedge clk) begin
    if (go && fault) begin
      page_frame[page] <= frame;
    end
  end

  always_comb begin
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_match[i] = tlb_valid[i] && (tlb_page[i] == page);
      if (tlb_match[i]) begin
        hit_frame = hit_frame | tlb_frame[i];
      end
    end
    hit = |tlb_match;
  end

  assign full = (frames_used == UW'(FRAME_COUNT));

  always_comb begin
    do_touch = 1'b0;
    do_push  = 1'b0;
    do_fill  = 1'b0;
    fault    = 1'b0;
    evict    = 1'b0;
    frame    = '0;
    priority if (hit) begin
      frame    = hit_frame;
      do_touch = 1'b1;
    end else if (resident[page]) begin
      frame    = mem_q;
      do_touch = 1'b1;
      do_fill  = 1'b1;
    end else begin
      fault   = 1'b1;
      do_fill = 1'b1;
      do_push = 1'b1;
      if (!full) begin
        frame = frames_used[FW-1:0];
      end else if (victim_valid) begin
        frame = victim_frame;
        evict = 1'b1;
      end
    end
  end

  assign ctl.touch = go & do_touch;
  assign ctl.push  = go & do_push;

  tptl_lru_chain #(.CELLS(FRAME_COUNT), .PW(PW), .FW(FW)) u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .new_page     (page),
    .new_frame    (frame),
    .victim_valid (victim_valid),
    .victim_page  (victim_page),
    .victim_frame (victim_frame)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_ptr    <= '0;
      frames_used <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid[i] <= 1'b0;
      end
      for (int p = 0; p < PAGE_COUNT; p++) begin
        resident[p] <= 1'b0;
      end
    end else if (go) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (evict && tlb_page[i] == victim_page) begin
          tlb_valid[i] <= 1'b0;
        end
      end
      if (do_fill) begin
        tlb_valid[fill_ptr] <= 1'b1;
        fill_ptr <= (fill_ptr == TW'(TLB_ENTRIES - 1)) ? '0 : fill_ptr + 1'b1;
      end
      if (evict) begin
        resident[victim_page] <= 1'b0;
      end
      if (fault) begin
        resident[page] <= 1'b1;
        if (!full) begin
          frames_used <= frames_used + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && do_fill) begin
      tlb_page[fill_ptr]  <= page;
      tlb_frame[fill_ptr] <= frame;
    end
  end

  assign phys_wide = (XW'(frame) << OW) | XW'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      physical_address <= phys_wide[QW-1:0];
      tlb_hit          <= hit;
      page_fault       <= fault;
      evicted_valid    <= evict;
      evicted_page     <= evict ? EPW'(victim_page) : '0;
    end
  end

  a_hit_resident: assert property (@(posedge clk) disable iff (rst)
    (state == tptl_pkg::S_LOOK && hit) |-> resident[page])
    else $error("tlb hit on a page that is not resident");

  a_tlb_unique: assert property (@(posedge clk) disable iff (rst)
    (state == tptl_pkg::S_LOOK) |-> $onehot0(tlb_match))
    else $error("page found in more than one tlb entry");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    frames_used <= UW'(FRAME_COUNT))
    else $error("frame count beyond frame total");

  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> (page_fault && !tlb_hit))
    else $error("eviction reported without a fault");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (go && evict) |-> full)
    else $error("eviction while free frames remain");

endmodule

>>> test/tb.sv
// testbench for the paged translation core: lru/tlb predictor with randomized handshakes
`timescale 1ns / 1ps

module tb;

  localparam int TLB_N   = 16;
  localparam int PAGES   = 256;
  localparam int FRAMES  = 128;

  typedef struct {
    logic [14:0] phys;
    logic        hit;
    logic        fault;
    logic        ev_valid;
    logic [7:0]  ev_page;
  } xlat_t;

  class xlat_scoreboard;
    int unsigned frame_of[PAGES];
    bit          resident[PAGES];
    int unsigned rank[PAGES];
    logic [7:0]  tlb_pg[TLB_N];
    int unsigned tlb_fr[TLB_N];
    bit          tlb_ok[TLB_N];
    int unsigned fill_ptr;
    int unsigned used;
    xlat_t       pending[$];
    int          errors;
    int          hits, faults, evictions, results;

    function void touch(int unsigned pg);
      int unsigned r;
      r = rank[pg];
      for (int k = 0; k < PAGES; k++)
        if (resident[k] && rank[k] > r) rank[k]--;
      rank[pg] = (used > 0) ? used - 1 : 0;
    endfunction

    function void fill(int unsigned pg, int unsigned fr);
      tlb_pg[fill_ptr] = pg[7:0];
      tlb_fr[fill_ptr] = fr;
      tlb_ok[fill_ptr] = 1'b1;
      fill_ptr = (fill_ptr + 1) % TLB_N;
    endfunction

    function void note_request(logic [15:0] addr);
      xlat_t       e;
      int unsigned pg, fr, victim;
      bit          found;
      pg = addr[15:8];
      fr = 0;
      e.hit = 0; e.fault = 0; e.ev_valid = 0; e.ev_page = 0;
      for (int k = 0; k < TLB_N; k++)
        if (tlb_ok[k] && tlb_pg[k] == pg) begin
          e.hit = 1;
          fr = tlb_fr[k];
          break;
        end
      if (e.hit) begin
        if (resident[pg]) touch(pg);
      end else if (resident[pg]) begin
        fr = frame_of[pg];
        touch(pg);
        fill(pg, fr);
      end else begin
        e.fault = 1;
        if (used < FRAMES) begin
          fr = used;
          used++;
          rank[pg] = used - 1;
        end else begin
          found = 0;
          victim = 0;
          for (int k = 0; k < PAGES; k++)
            if (resident[k] && rank[k] == 0) begin
              victim = k;
              found = 1;
              break;
            end
          if (found) begin
            fr = frame_of[victim];
            resident[victim] = 0;
            e.ev_valid = 1;
            e.ev_page = victim[7:0];
            for (int k = 0; k < TLB_N; k++)
              if (tlb_ok[k] && tlb_pg[k] == victim) tlb_ok[k] = 0;
            for (int k = 0; k < PAGES; k++)
              if (resident[k] && rank[k] > 0) rank[k]--;
          end
          rank[pg] = FRAMES - 1;
        end
        frame_of[pg] = fr;
        resident[pg] = 1;
        fill(pg, fr);
      end
      e.phys = 15'(((fr << 8) | addr[7:0]) & 32'h7fff);
      pending.push_back(e);
    endfunction

    task report(string what, int got, int want);
      $display("error: %s got %0h expected %0h (result %0d)", what, got, want, results);
      errors++;
    endtask

    task check_result(xlat_t r);
      xlat_t e;
      if (pending.size() == 0) begin
        report("unexpected result, phys", r.phys, 0);
        return;
      end
      e = pending.pop_front();
      results++;
      if (r.phys !== e.phys) report("physical_address", r.phys, e.phys);
      if (r.hit !== e.hit) report("tlb_hit", r.hit, e.hit);
      if (r.fault !== e.fault) report("page_fault", r.fault, e.fault);
      if (r.ev_valid !== e.ev_valid) report("evicted_valid", r.ev_valid, e.ev_valid);
      if (r.ev_page !== e.ev_page) report("evicted_page", r.ev_page, e.ev_page);
      hits += e.hit;
      faults += e.fault;
      evictions += e.ev_valid;
    endtask
  endclass

  logic        clk, rst;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [15:0] logical_address;
  logic [14:0] physical_address;
  logic        tlb_hit, page_fault, evicted_valid;
  logic [7:0]  evicted_page;

  xlat_scoreboard sb;
  int send_idle_pct, recv_stall_pct;

  tlb_paged_translation_lru_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .logical_address(logical_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .physical_address(physical_address), .tlb_hit(tlb_hit), .page_fault(page_fault),
    .evicted_valid(evicted_valid), .evicted_page(evicted_page)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tlb_paged_translation_lru_core: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    xlat_t r;
    if (!rst && out_valid && !out_stall) begin
      r.phys = physical_address;
      r.hit = tlb_hit;
      r.fault = page_fault;
      r.ev_valid = evicted_valid;
      r.ev_page = evicted_page;
      sb.check_result(r);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task send_request(logic [15:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      logical_address <= 16'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    logical_address <= addr;
    do @(posedge clk); while (in_stall);
    sb.note_request(addr);
  endtask

  function automatic logic [15:0] pick_address();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40)
      return {8'($urandom_range(11)), 8'($urandom)};
    else if (sel < 70)
      return {8'($urandom_range(40)), 8'($urandom)};
    else
      return 16'($urandom);
  endfunction

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    logical_address = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, hit after miss, tlb wrap then revisit from the page table
    send_request(16'h0000);
    send_request(16'hffff);
    send_request(16'h00ff);
    send_request(16'hff00);
    send_request(16'h5500);
    send_request(16'haaff);
    for (int p = 1; p <= 17; p++) send_request({8'(p), 8'(p * 13)});
    send_request(16'h0042);
    send_request(16'hff7f);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 19 : (ph == 1) ? 79 : 0;
      recv_stall_pct = (ph == 0) ? 79 : (ph == 1) ? 19 : 0;
      for (int n = 0; n < 400; n++) send_request(pick_address());
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: %0d tlb hits, %0d page faults, %0d evictions",
             sb.results, sb.hits, sb.faults, sb.evictions);
    if (sb.errors == 0)
      $display("tlb_paged_translation_lru_core: match");
    else
      $display("tlb_paged_translation_lru_core: mismatch");
    $finish;
  end
endmodule
